[src/jsu_pkg.sv]
// Types, character codes and decode functions for the JSON string unescape block.
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} jsu_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
		logic       bad_escape;
	} jsu_out_t;

	typedef enum logic [2:0] {
		PH_TEXT = 3'd0,
		PH_BSL  = 3'd1,
		PH_HEX1 = 3'd2,
		PH_HEX2 = 3'd3,
		PH_HEX3 = 3'd4,
		PH_HEX4 = 3'd5
	} jsu_phase_t;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;

	// Returns {ok, value}; ok is low when c is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_D0 && c <= CH_D9) begin
			d = c - CH_D0;
			return {1'b1, d[3:0]};
		end
		if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = c - CH_LC_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = c - CH_UC_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	// Returns {ok, byte} for a one-byte escape letter; byte is zero when not ok.
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			CH_QUOTE: r = {1'b1, CH_QUOTE};
			CH_SLASH: r = {1'b1, CH_SLASH};
			CH_BSL:   r = {1'b1, CH_BSL};
			CH_LC_B:  r = {1'b1, CH_BS};
			CH_LC_F:  r = {1'b1, CH_FF};
			CH_LC_N:  r = {1'b1, CH_LF};
			CH_LC_R:  r = {1'b1, CH_CR};
			CH_LC_T:  r = {1'b1, CH_TAB};
			default:  r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[src/json_string_unescape_core.sv]
// Streaming decoder for the escape sequences of a JSON string body.
//
// Input channel (item, item_valid, item_stall): one source byte per transfer,
// with in_last on the final byte of the string. Output channel (result,
// result_valid, result_stall): zero or one result per source byte. A result
// is sent when a byte is decoded, when an escape error is found, or on the
// last byte of a string. A \u escape yields two bytes, one on its second and
// one on its fourth hex digit.
//
// Each accepted byte is held in an input register, decoded against the
// escape phase and the pending hex nibble, and written to the result
// register, from which its result is offered. One byte can be accepted
// every cycle while the receiver does not stall the result register. The
// escape state advances one byte per cycle when the input register
// moves on, which sets that rate.
//
// Reset empties both registers and returns the decoder to plain text. When
// the receiver stalls, the result register holds its transfer and the input
// register keeps one more byte; item_stall rises once both are full.
module json_string_unescape_core
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  jsu_in_t  item,
	input  logic     item_valid,
	output logic     item_stall,
	output jsu_out_t result,
	output logic     result_valid,
	input  logic     result_stall
);

	jsu_in_t    item_s1;
	logic       valid_s1;
	jsu_phase_t phase_q, phase_nxt;
	logic [3:0] held_q, held_nxt;
	jsu_out_t   result_q, res;
	logic       result_valid_q;
	logic       emit;
	logic       advance;
	logic       accept;
	logic [4:0] hv;
	logic [8:0] em;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			held_q  <= 4'd0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

	always_comb begin
		phase_nxt    = PH_TEXT;
		held_nxt     = held_q;
		res          = '0;
		hv           = hex_val(item_s1.in_byte);
		em           = esc_map(item_s1.in_byte);
		unique case (phase_q)
			PH_BSL: begin
				if (item_s1.in_byte == CH_LC_U) begin
					phase_nxt = PH_HEX1;
				end else begin
					res.has_byte   = em[8];
					res.out_byte   = em[7:0];
					res.bad_escape = !em[8];
				end
			end
			PH_HEX1, PH_HEX3: begin
				if (hv[4]) begin
					held_nxt  = hv[3:0];
					phase_nxt = (phase_q == PH_HEX1) ? PH_HEX2 : PH_HEX4;
				end else begin
					res.bad_escape = 1'b1;
				end
			end
			PH_HEX2, PH_HEX4: begin
				if (hv[4]) begin
					res.has_byte = 1'b1;
					res.out_byte = {held_q, hv[3:0]};
					phase_nxt    = (phase_q == PH_HEX2) ? PH_HEX3 : PH_TEXT;
				end else begin
					res.bad_escape = 1'b1;
				end
			end
			default: begin
				if (item_s1.in_byte == CH_BSL) begin
					phase_nxt = PH_BSL;
				end else begin
					res.has_byte = 1'b1;
					res.out_byte = item_s1.in_byte;
				end
			end
		endcase
		// An escape still open at the end of the string is an error.
		if (item_s1.in_last) begin
			if (phase_nxt != PH_TEXT) begin
				res.bad_escape = 1'b1;
			end
			phase_nxt = PH_TEXT;
			held_nxt  = 4'd0;
		end
		res.out_last = item_s1.in_last;
		emit = res.has_byte || res.bad_escape || item_s1.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

[src/jsu_checker.sv]
// Port-level assertions for the JSON string unescape block, bound to its top level.
module jsu_assertions
	import jsu_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input jsu_in_t  item,
	input logic     item_valid,
	input logic     item_stall,
	input jsu_out_t result,
	input logic     result_valid,
	input logic     result_stall
);

	// A stalled result transfer keeps its valid and its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A result exists only for a decoded byte, an error or the end of a string.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_byte && !result.bad_escape |-> result.out_last)
		else $error("result without cause");

	// A byte and an error together only happen on a truncated escape at the end.
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.has_byte && result.bad_escape |-> result.out_last)
		else $error("byte with error not at end of string");

	// With the output empty, a new result comes from an input transfer that has passed the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without matching input transfer");

endmodule

bind json_string_unescape_core jsu_assertions u_jsu_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.item         (item),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result       (result),
	.result_valid (result_valid),
	.result_stall (result_stall)
);

[tb/jsu_checker.sv]
// Checker for the JSON string unescape block: predicts decoded results and compares transfers.
`timescale 1ns / 100ps

module jsu_checker
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  jsu_in_t  item,
	input  logic     item_valid,
	input  logic     item_stall,
	input  jsu_out_t result,
	input  logic     result_valid,
	input  logic     result_stall,
	output int       mismatches,
	output int       pending
);

	jsu_out_t   decoded_q[$];
	jsu_phase_t phase;
	logic [3:0] hi_nibble;

	// Value of a hex digit in either case, or -1 for any other byte.
	function automatic int hex_value(input logic [7:0] c);
		if (c >= CH_D0 && c <= CH_D9) return int'(c - CH_D0);
		if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
		if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
		return -1;
	endfunction

	task automatic decode_byte(input jsu_in_t it);
		jsu_out_t   r;
		jsu_phase_t nxt;
		int         v;
		r = '0;
		nxt = PH_TEXT;
		v = hex_value(it.in_byte);
		case (phase)
			PH_BSL: begin
				r.has_byte = 1'b1;
				case (it.in_byte)
					CH_QUOTE, CH_SLASH, CH_BSL: r.out_byte = it.in_byte;
					CH_LC_B: r.out_byte = CH_BS;
					CH_LC_F: r.out_byte = CH_FF;
					CH_LC_N: r.out_byte = CH_LF;
					CH_LC_R: r.out_byte = CH_CR;
					CH_LC_T: r.out_byte = CH_TAB;
					CH_LC_U: begin
						r.has_byte = 1'b0;
						nxt = PH_HEX1;
					end
					default: begin
						r.has_byte = 1'b0;
						r.bad_escape = 1'b1;
					end
				endcase
			end
			PH_HEX1, PH_HEX3: begin
				if (v < 0) begin
					r.bad_escape = 1'b1;
				end else begin
					hi_nibble = v[3:0];
					nxt = (phase == PH_HEX1) ? PH_HEX2 : PH_HEX4;
				end
			end
			PH_HEX2, PH_HEX4: begin
				if (v < 0) begin
					r.bad_escape = 1'b1;
				end else begin
					r.out_byte = {hi_nibble, v[3:0]};
					r.has_byte = 1'b1;
					nxt = (phase == PH_HEX2) ? PH_HEX3 : PH_TEXT;
				end
			end
			default: begin
				if (it.in_byte == CH_BSL) begin
					nxt = PH_BSL;
				end else begin
					r.out_byte = it.in_byte;
					r.has_byte = 1'b1;
				end
			end
		endcase
		// The end of a string closes any open escape, which counts as an error.
		if (it.in_last) begin
			if (nxt != PH_TEXT) r.bad_escape = 1'b1;
			nxt = PH_TEXT;
			hi_nibble = '0;
			r.out_last = 1'b1;
		end
		phase = nxt;
		if (r.has_byte || r.bad_escape || r.out_last) decoded_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		jsu_out_t want;
		if (!arst_n) begin
			phase = PH_TEXT;
			hi_nibble = '0;
			decoded_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// Results are checked before this edge's input is decoded.
			if (result_valid && !result_stall) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: result %h with none expected", $time, result);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h actual %h",
							$time, want.out_byte, result.out_byte);
						mismatches++;
					end
					if (result.has_byte !== want.has_byte) begin
						$display("%0t: has_byte expected %b actual %b",
							$time, want.has_byte, result.has_byte);
						mismatches++;
					end
					if (result.out_last !== want.out_last) begin
						$display("%0t: out_last expected %b actual %b",
							$time, want.out_last, result.out_last);
						mismatches++;
					end
					if (result.bad_escape !== want.bad_escape) begin
						$display("%0t: bad_escape expected %b actual %b",
							$time, want.bad_escape, result.bad_escape);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) decode_byte(item);
			pending = decoded_q.size();
		end
	end

endmodule

[tb/tb_json_string_unescape_core.sv]
// Testbench top for the JSON string unescape block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_json_string_unescape_core
	import jsu_pkg::*;
;

	logic     clk;
	logic     arst_n;
	jsu_in_t  item;
	logic     item_valid;
	logic     item_stall;
	jsu_out_t result;
	logic     result_valid;
	logic     result_stall;
	int       mismatches;
	int       pending;

	logic [7:0] text[$];
	int         sent;
	int         send_calm;
	int         stall_calm;
	int         stall_left;

	logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_SLASH, CH_BSL, CH_LC_B,
		CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};
	// Bytes just outside the hex digit ranges, plus the byte extremes.
	logic [7:0] non_hex[8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};

	json_string_unescape_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	jsu_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly no gap, often a short one, rarely a long one, with calm stretches.
	task automatic draw_gap(inout int calm, input int long_max, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if (r < 3) begin
			calm = $urandom_range(20, 80);
			gap = 0;
		end else if (r < 60) begin
			gap = 0;
		end else if (r < 93) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(4, long_max);
		end
	endtask

	function automatic logic [7:0] rand_hex();
		int n;
		n = $urandom_range(0, 15);
		if (n < 10) return 8'(CH_D0 + n);
		return 8'(($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + n - 10);
	endfunction

	// Called just after a falling edge; returns just after the falling edge
	// that follows the transfer.
	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		draw_gap(send_calm, 20, gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= {b, last};
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(input logic end_mark);
		for (int i = 0; i < text.size(); i++)
			send_item(text[i], end_mark && i == text.size() - 1);
		text.delete();
	endtask

	task automatic queue_str(input string s);
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	initial begin
		result_stall = 1'b0;
		stall_calm = 0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				draw_gap(stall_calm, 30, stall_left);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int  nseg;
		int  kind;
		int  ndig;
		logic cut;
		arst_n = 1'b0;
		item = '0;
		item_valid = 1'b0;
		sent = 0;
		send_calm = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Byte extremes pass through untouched.
		text.push_back(8'h00);
		text.push_back(8'hFF);
		send_text(1'b1);
		// Every one-byte escape.
		queue_str("\\\"\\/\\\\\\b\\f\\n\\r\\t");
		send_text(1'b1);
		// A unicode escape with mixed-case digits.
		queue_str("\\u09aF");
		send_text(1'b1);
		// Unknown letter, bad hex digit, then an escape cut short by the end.
		queue_str("\\x\\uG\\u1");
		send_text(1'b1);

		while (sent < 740) begin
			nseg = $urandom_range(1, 10);
			cut = 1'b0;
			for (int s = 0; s < nseg && !cut; s++) begin
				kind = $urandom_range(0, 99);
				if (kind < 50) begin
					text.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 75) begin
					text.push_back(CH_BSL);
					text.push_back(esc_letters[3'($urandom_range(0, 7))]);
				end else if (kind < 90) begin
					text.push_back(CH_BSL);
					text.push_back(CH_LC_U);
					repeat (4) text.push_back(rand_hex());
				end else begin
					text.push_back(CH_BSL);
					case ($urandom_range(0, 2))
						0: text.push_back(8'($urandom_range(0, 255)));
						1: begin
							text.push_back(CH_LC_U);
							ndig = $urandom_range(0, 3);
							repeat (ndig) text.push_back(rand_hex());
							text.push_back(non_hex[3'($urandom_range(0, 7))]);
						end
						default: begin
							// Leave the escape open and end the string here.
							if ($urandom_range(0, 3) != 0) begin
								text.push_back(CH_LC_U);
								ndig = $urandom_range(0, 3);
								repeat (ndig) text.push_back(rand_hex());
							end
							cut = 1'b1;
						end
					endcase
				end
			end
			// Some strings run on into the next without an end mark.
			send_text(cut || $urandom_range(0, 9) != 0);
		end
		item_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
